>>> rtl/bounded_bag_with_aggregates_defines.svh
// assertion macros for the top-level rtl
`ifndef BOUNDED_BAG_WITH_AGGREGATES_DEFINES_SVH
`define BOUNDED_BAG_WITH_AGGREGATES_DEFINES_SVH

// check that cons holds in the same cycle as ante
`define BBAG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante
`define BBAG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bbag_pkg.sv
package bbag_pkg;

  // sizes fixed by the item fields
  localparam int DEPTH_DEF = 16;
  localparam int CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd5;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 36;
  localparam int CNT_OUT_W = 5;
  localparam int OUT_PAD_W = 7;
  localparam int OUT_W     = CNT_OUT_W + 2 * VAL_W + SUM_W + OUT_PAD_W;
  localparam logic signed [VAL_W-1:0] ENTRY_RESET = 32'sd1;

  // sequencer steps
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD,
    S_DEL_CHK,
    S_DEL_CMP,
    S_DEL_MOVE,
    S_DEL_CLR,
    S_AGG_INIT,
    S_AGG_RUN,
    S_AGG_DRAIN,
    S_DONE
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_ACCEPT,
    C_OP_DEL,
    C_IDX_PAST,
    C_NO_MATCH,
    C_MORE,
    C_OUT_FREE
  } cond_t;

  // memory write select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_ADD,
    WR_MOVE,
    WR_CLEAR
  } wr_sel_t;

  // index register operation
  typedef enum logic [1:0] {
    IDX_KEEP,
    IDX_CLR,
    IDX_INC,
    IDX_INC_NM
  } idx_op_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  stay;
    logic  take_in;
    logic  emit;
  } seq_ctrl_t;

  typedef struct packed {
    wr_sel_t wr;
    idx_op_t idx_op;
    logic    rd_last;
    logic    agg_clr;
    logic    agg_issue;
  } dp_ctrl_t;

  typedef struct packed {
    seq_ctrl_t seq;
    dp_ctrl_t  dp;
  } ucode_t;

  typedef struct packed {
    logic op_del;
    logic idx_past;
    logic match;
    logic more;
  } dp_stat_t;

  // control store: one word per step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      S_IDLE:      w = '{'{C_ACCEPT,   S_DISPATCH,  1'b1, 1'b1, 1'b0},
                         '{WR_NONE,  IDX_CLR,    1'b0, 1'b0, 1'b0}};
      S_DISPATCH:  w = '{'{C_OP_DEL,   S_DEL_CHK,   1'b0, 1'b0, 1'b0},
                         '{WR_NONE,  IDX_KEEP,   1'b0, 1'b0, 1'b0}};
      S_ADD:       w = '{'{C_ALWAYS,   S_AGG_INIT,  1'b0, 1'b0, 1'b0},
                         '{WR_ADD,   IDX_KEEP,   1'b0, 1'b0, 1'b0}};
      S_DEL_CHK:   w = '{'{C_IDX_PAST, S_AGG_INIT,  1'b0, 1'b0, 1'b0},
                         '{WR_NONE,  IDX_KEEP,   1'b0, 1'b0, 1'b0}};
      S_DEL_CMP:   w = '{'{C_NO_MATCH, S_DEL_CHK,   1'b0, 1'b0, 1'b0},
                         '{WR_NONE,  IDX_INC_NM, 1'b1, 1'b0, 1'b0}};
      S_DEL_MOVE:  w = '{'{C_NEVER,    S_IDLE,      1'b0, 1'b0, 1'b0},
                         '{WR_MOVE,  IDX_KEEP,   1'b0, 1'b0, 1'b0}};
      S_DEL_CLR:   w = '{'{C_ALWAYS,   S_DEL_CHK,   1'b0, 1'b0, 1'b0},
                         '{WR_CLEAR, IDX_KEEP,   1'b0, 1'b0, 1'b0}};
      S_AGG_INIT:  w = '{'{C_NEVER,    S_IDLE,      1'b0, 1'b0, 1'b0},
                         '{WR_NONE,  IDX_CLR,    1'b0, 1'b1, 1'b0}};
      S_AGG_RUN:   w = '{'{C_MORE,     S_AGG_RUN,   1'b0, 1'b0, 1'b0},
                         '{WR_NONE,  IDX_INC,    1'b0, 1'b0, 1'b1}};
      S_AGG_DRAIN: w = '{'{C_NEVER,    S_IDLE,      1'b0, 1'b0, 1'b0},
                         '{WR_NONE,  IDX_KEEP,   1'b0, 1'b0, 1'b0}};
      S_DONE:      w = '{'{C_OUT_FREE, S_IDLE,      1'b1, 1'b0, 1'b1},
                         '{WR_NONE,  IDX_KEEP,   1'b0, 1'b0, 1'b0}};
      default:     w = '{'{C_ALWAYS,   S_IDLE,      1'b0, 1'b0, 1'b0},
                         '{WR_NONE,  IDX_KEEP,   1'b0, 1'b0, 1'b0}};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/bbag_datapath.sv
module bbag_datapath #(
  parameter int DEPTH = bbag_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bbag_pkg::dp_ctrl_t                   ctrl,
  input  logic                                 in_load,
  input  logic                                 in_op,
  input  logic signed [bbag_pkg::VAL_W-1:0]    in_value,
  input  logic [bbag_pkg::CAP_W-1:0]           capacity,
  output bbag_pkg::dp_stat_t                   stat,
  output logic [bbag_pkg::CNT_OUT_W-1:0]       entry_count,
  output logic signed [bbag_pkg::VAL_W-1:0]    largest,
  output logic signed [bbag_pkg::VAL_W-1:0]    smallest,
  output logic signed [bbag_pkg::SUM_W-1:0]    total,
  output logic                                 add_dropped
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > bbag_pkg::CAP_W) ? CW : bbag_pkg::CAP_W;
  localparam int VW = bbag_pkg::VAL_W;
  localparam int SW = bbag_pkg::SUM_W;

  logic signed [VW-1:0] mem [DEPTH];
  logic signed [VW-1:0] rdata;

  logic [CW-1:0]        cnt;
  logic [CW-1:0]        idx;
  logic                 op;
  logic signed [VW-1:0] val;
  logic                 dropped;
  logic signed [VW-1:0] hi;
  logic signed [VW-1:0] lo;
  logic signed [SW-1:0] sum;
  logic                 first;
  logic                 pend;

  logic [CW-1:0]        last_full;
  logic [AW-1:0]        last_addr;
  logic [AW-1:0]        rd_addr;
  logic [CW:0]          idx_p1;
  logic [KW-1:0]        cnt_w;
  logic                 room;
  logic                 match;
  logic                 idx_past;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [VW-1:0] wr_data;

  // address and compare logic
  assign last_full = cnt - CW'(1);
  assign last_addr = last_full[AW-1:0];
  assign rd_addr   = ctrl.rd_last ? last_addr : idx[AW-1:0];
  assign idx_p1    = {1'b0, idx} + (CW + 1)'(1);
  assign cnt_w     = KW'(cnt);
  assign room      = (cnt_w < KW'(capacity)) && (cnt != CW'(DEPTH));
  assign match     = (rdata == val);
  assign idx_past  = (idx >= cnt);

  assign stat.op_del   = op;
  assign stat.idx_past = idx_past;
  assign stat.match    = match;
  assign stat.more     = (idx_p1 < {1'b0, cnt});

  // memory write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rdata;
    case (ctrl.wr)
      bbag_pkg::WR_ADD: begin
        wr_en   = room;
        wr_addr = cnt[AW-1:0];
        wr_data = val;
      end
      bbag_pkg::WR_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = rdata;
      end
      bbag_pkg::WR_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = last_addr;
        wr_data = bbag_pkg::ENTRY_RESET;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // entry storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // count, index and aggregate control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      idx   <= '0;
      pend  <= 1'b0;
      first <= 1'b1;
    end else begin
      if (ctrl.wr == bbag_pkg::WR_ADD && room) begin
        cnt <= cnt + CW'(1);
      end else if (ctrl.wr == bbag_pkg::WR_CLEAR) begin
        cnt <= last_full;
      end
      case (ctrl.idx_op)
        bbag_pkg::IDX_CLR:    idx <= '0;
        bbag_pkg::IDX_INC:    idx <= idx_p1[CW-1:0];
        bbag_pkg::IDX_INC_NM: idx <= match ? idx : idx_p1[CW-1:0];
        default:              idx <= idx;
      endcase
      if (ctrl.agg_clr) begin
        pend  <= 1'b0;
        first <= 1'b1;
      end else begin
        pend <= ctrl.agg_issue && !idx_past;
        if (pend) begin
          first <= 1'b0;
        end
      end
    end
  end

  // item payload and aggregates
  always_ff @(posedge clk) begin
    if (in_load) begin
      op      <= in_op;
      val     <= in_value;
      dropped <= 1'b0;
    end else if (ctrl.wr == bbag_pkg::WR_ADD) begin
      dropped <= !room;
    end
    if (ctrl.agg_clr) begin
      hi  <= bbag_pkg::ENTRY_RESET;
      lo  <= bbag_pkg::ENTRY_RESET;
      sum <= '0;
    end else if (pend) begin
      if (first) begin
        hi <= rdata;
        lo <= rdata;
      end else begin
        if (rdata > hi) begin
          hi <= rdata;
        end
        if (rdata < lo) begin
          lo <= rdata;
        end
      end
      sum <= sum + {{(SW - VW){rdata[VW-1]}}, rdata};
    end
  end

  assign entry_count = cnt_w[bbag_pkg::CNT_OUT_W-1:0];
  assign largest     = hi;
  assign smallest    = lo;
  assign total       = sum;
  assign add_dropped = dropped;

endmodule

>>> rtl/bounded_bag_with_aggregates.sv
// Unordered bag of signed 32-bit values, holding at most min(capacity, DEPTH)
// entries. Each input item adds s_tdata (s_tuser = 0; dropped and flagged when
// the bag is full) or deletes every entry equal to s_tdata (s_tuser = 1), by
// moving the last entry into each freed slot. One result follows every item
// with the count, largest, smallest and 36-bit sum; an empty bag reports 1 as
// largest and smallest. Items are handled one at a time by a small microcoded
// sequencer over a single-port-write, one-read entry memory, so the entry
// memory port sets the rate. The aggregate scan runs also for an empty bag,
// and the next item is not taken until the result has been loaded into the
// output register. No clearing pass is needed after reset; the fill count
// tracks which entries are live. capacity may be rewritten through
// cfg_wen / cfg_wdata while the block is idle.
`include "bounded_bag_with_aggregates_defines.svh"

module bounded_bag_with_aggregates #(
  parameter int DEPTH = bbag_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bbag_pkg::VAL_W-1:0]      s_tdata,   // [31:0] value
  input  logic [0:0]                      s_tuser,   // [0] operation
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [4:0] entry_count, [36:5] largest, [68:37] smallest, [104:69] total, rest zero
  output logic [bbag_pkg::OUT_W-1:0]      m_tdata,
  output logic [0:0]                      m_tuser,   // [0] add_dropped
  input  logic                            cfg_wen,
  input  logic [bbag_pkg::CAP_W-1:0]      cfg_wdata
);

  logic [bbag_pkg::CAP_W-1:0]            capacity;
  bbag_pkg::step_t                       step;
  bbag_pkg::step_t                       step_next;
  bbag_pkg::ucode_t                      ucode;
  bbag_pkg::dp_stat_t                    stat;
  logic                                  accept;
  logic                                  out_free;
  logic                                  out_load;
  logic                                  cond_true;
  logic [bbag_pkg::CNT_OUT_W-1:0]        entry_count;
  logic signed [bbag_pkg::VAL_W-1:0]     largest;
  logic signed [bbag_pkg::VAL_W-1:0]     smallest;
  logic signed [bbag_pkg::SUM_W-1:0]     total;
  logic                                  add_dropped;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bbag_pkg::CAP_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  // control word of the current step
  always_comb begin
    ucode = bbag_pkg::ucode_rom(step);
  end

  assign s_tready = ucode.seq.take_in;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ucode.seq.emit && out_free;

  // jump condition select
  always_comb begin
    case (ucode.seq.cond)
      bbag_pkg::C_ALWAYS:   cond_true = 1'b1;
      bbag_pkg::C_ACCEPT:   cond_true = accept;
      bbag_pkg::C_OP_DEL:   cond_true = stat.op_del;
      bbag_pkg::C_IDX_PAST: cond_true = stat.idx_past;
      bbag_pkg::C_NO_MATCH: cond_true = !stat.match;
      bbag_pkg::C_MORE:     cond_true = stat.more;
      bbag_pkg::C_OUT_FREE: cond_true = out_free;
      default:              cond_true = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (cond_true) begin
      step_next = ucode.seq.target;
    end else if (ucode.seq.stay) begin
      step_next = step;
    end else begin
      step_next = bbag_pkg::step_t'(4'(step) + 4'd1);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bbag_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  bbag_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ucode.dp),
    .in_load     (accept),
    .in_op       (s_tuser[0]),
    .in_value    (s_tdata),
    .capacity    (capacity),
    .stat        (stat),
    .entry_count (entry_count),
    .largest     (largest),
    .smallest    (smallest),
    .total       (total),
    .add_dropped (add_dropped)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{bbag_pkg::OUT_PAD_W{1'b0}}, total, smallest, largest, entry_count};
      m_tuser <= add_dropped;
    end
  end

  // checks
  `BBAG_ASSERT_NEXT(a_one_item_at_a_time, clk, rst, accept, !s_tready, "item taken while busy")
  `BBAG_ASSERT_SAME(a_cmp_in_range, clk, rst, step == bbag_pkg::S_DEL_CMP,
                    !stat.idx_past, "compare past count")
  `BBAG_ASSERT_SAME(a_move_after_match, clk, rst, step == bbag_pkg::S_DEL_MOVE,
                    $past(stat.match), "move without match")

endmodule

>>> sim/tb_bounded_bag_with_aggregates.sv
`timescale 1ns / 100ps

module tb_bounded_bag_with_aggregates;

  localparam int DEPTH = bbag_pkg::DEPTH_DEF;
  localparam int VAL_W = bbag_pkg::VAL_W;
  localparam int SUM_W = bbag_pkg::SUM_W;
  localparam int CAP_W = bbag_pkg::CAP_W;
  localparam int CNT_OUT_W = bbag_pkg::CNT_OUT_W;
  localparam int OUT_W = bbag_pkg::OUT_W;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1200;
  localparam int LONG_HOLD = 250;

  typedef enum logic {
    BAG_ADD = 1'b0,
    BAG_DEL = 1'b1
  } bag_op_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_CHECKED
  } row_kind_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic [VAL_W-1:0]     largest;
    logic [VAL_W-1:0]     smallest;
    logic [SUM_W-1:0]     total;
    logic                 dropped;
  } bag_summary_t;

  typedef struct packed {
    row_kind_t        kind;
    bag_op_t          op;
    logic [VAL_W-1:0] value;
    logic [CAP_W-1:0] cap;
    bag_summary_t     want;
  } bag_row_t;

  localparam bag_summary_t EMPTY_BAG = '{5'd0, 32'd1, 32'd1, 36'd0, 1'b0};
  localparam bag_summary_t NO_CHECK = '0;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [VAL_W-1:0] s_tdata;
  logic [0:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_wen;
  logic [CAP_W-1:0] cfg_wdata;

  // bag mirror kept in step with accepted items
  logic signed [VAL_W-1:0] mirror_slots [DEPTH];
  int mirror_held;
  logic [CAP_W-1:0] mirror_capacity;

  bag_summary_t pending_summaries [$];
  bag_row_t directed_rows [$];
  int mismatches = 0;
  int results_seen = 0;
  int items_offered = 0;
  int cycle_count = 0;
  bit burst_mode = 1'b0;
  bit long_hold_done = 1'b0;

  bounded_bag_with_aggregates DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one item to the mirror and return the summary it should report
  function automatic bag_summary_t apply_to_bag(bag_op_t op,
                                                logic [VAL_W-1:0] val);
    bag_summary_t s;
    int lim;
    int i;
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] lo;
    logic signed [SUM_W-1:0] sum;
    s = '0;
    lim = (mirror_capacity > DEPTH) ? DEPTH : int'(mirror_capacity);
    if (op == BAG_ADD) begin
      if (mirror_held < lim) begin
        mirror_slots[mirror_held] = val;
        mirror_held++;
      end else begin
        s.dropped = 1'b1;
      end
    end else begin
      // swap-remove, then look again at the entry that moved in
      i = 0;
      while (i < mirror_held) begin
        if (mirror_slots[i] == val) begin
          mirror_slots[i] = mirror_slots[mirror_held-1];
          mirror_slots[mirror_held-1] = bbag_pkg::ENTRY_RESET;
          mirror_held--;
        end else begin
          i++;
        end
      end
    end
    hi = mirror_slots[0];
    lo = mirror_slots[0];
    sum = '0;
    for (i = 0; i < mirror_held; i++) begin
      if (mirror_slots[i] > hi) hi = mirror_slots[i];
      if (mirror_slots[i] < lo) lo = mirror_slots[i];
      sum = sum + {{(SUM_W-VAL_W){mirror_slots[i][VAL_W-1]}}, mirror_slots[i]};
    end
    s.count = mirror_held[CNT_OUT_W-1:0];
    s.largest = hi;
    s.smallest = lo;
    s.total = sum;
    return s;
  endfunction

  function automatic bag_row_t mk_row(row_kind_t kind, bag_op_t op,
                                      logic [VAL_W-1:0] value,
                                      logic [CAP_W-1:0] cap, bag_summary_t want);
    bag_row_t r;
    r.kind = kind;
    r.op = op;
    r.value = value;
    r.cap = cap;
    r.want = want;
    return r;
  endfunction

  // offer one item, wait for the handshake, then queue its summary
  task automatic offer_item(input bag_op_t op, input logic [VAL_W-1:0] val,
                            input bit typed = 1'b0, input bag_summary_t want = '0);
    int gap;
    bag_summary_t predicted;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_to_bag(op, val);
    pending_summaries.push_back(typed ? want : predicted);
    items_offered++;
  endtask

  // write capacity once every pending summary is back and the block is idle
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    s_tvalid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_wen <= 1'b0;
    mirror_capacity = cap;
  endtask

  // stimulus
  initial begin
    bag_row_t row;
    logic [VAL_W-1:0] pool [6];
    logic [CAP_W-1:0] cap_plan [11];
    logic [CAP_W-1:0] cap;
    logic [VAL_W-1:0] val;
    bag_op_t op;
    int phase;
    int del_pct;
    int n;
    int r;

    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    rst = 1'b1;
    for (int i = 0; i < DEPTH; i++) mirror_slots[i] = bbag_pkg::ENTRY_RESET;
    mirror_held = 0;
    mirror_capacity = bbag_pkg::CAP_RESET;
    cap_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8, 5'd16, 5'd5, 5'd12, 5'd2, 5'd16};

    // directed rows: extremes, drops, duplicate deletes, capacity corners
    directed_rows.push_back(mk_row(ROW_CHECKED, BAG_DEL, 32'd5, '0, EMPTY_BAG));
    directed_rows.push_back(mk_row(ROW_CHECKED, BAG_ADD, 32'h7FFFFFFF, '0,
      '{5'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 36'h07FFFFFFF, 1'b0}));
    directed_rows.push_back(mk_row(ROW_CHECKED, BAG_ADD, 32'h80000000, '0,
      '{5'd2, 32'h7FFFFFFF, 32'h80000000, 36'hFFFFFFFFF, 1'b0}));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_ADD, 32'd7, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_ADD, 32'hFFFFFFFF, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_ADD, 32'd7, '0, NO_CHECK));
    // bag full at reset capacity
    directed_rows.push_back(mk_row(ROW_CHECKED, BAG_ADD, 32'd3, '0,
      '{5'd5, 32'h7FFFFFFF, 32'h80000000, 36'd12, 1'b1}));
    // the moved-in entry also matches
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_DEL, 32'd7, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_DEL, 32'h7FFFFFFF, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_DEL, 32'hFFFFFFFF, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_CHECKED, BAG_DEL, 32'h80000000, '0, EMPTY_BAG));
    // zero capacity drops every add
    directed_rows.push_back(mk_row(ROW_CFG, BAG_ADD, '0, 5'd0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_CHECKED, BAG_ADD, 32'd9, '0,
      '{5'd0, 32'd1, 32'd1, 36'd0, 1'b1}));
    directed_rows.push_back(mk_row(ROW_CFG, BAG_ADD, '0, 5'd2, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_ADD, 32'd0, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_ADD, 32'hFFFFFFFB, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_CHECKED, BAG_ADD, 32'd4, '0,
      '{5'd2, 32'd0, 32'hFFFFFFFB, 36'hFFFFFFFFB, 1'b1}));
    // capacity lowered under the held count
    directed_rows.push_back(mk_row(ROW_CFG, BAG_ADD, '0, 5'd1, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_ADD, 32'd6, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_DEL, 32'd0, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_ADD, 32'd6, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_DEL, 32'hFFFFFFFB, '0, NO_CHECK));
    // capacity above depth saturates
    directed_rows.push_back(mk_row(ROW_CFG, BAG_ADD, '0, 5'd31, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_ADD, 32'd1, '0, NO_CHECK));
    directed_rows.push_back(mk_row(ROW_ITEM, BAG_DEL, 32'd1, '0, NO_CHECK));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) begin
        write_capacity(row.cap);
      end else begin
        offer_item(row.op, row.value, row.kind == ROW_CHECKED, row.want);
      end
    end

    // random phases, each under its own capacity
    phase = 0;
    while (items_offered < ITEM_TARGET) begin
      cap = (phase < 11) ? cap_plan[phase] : CAP_W'($urandom_range(0, 31));
      write_capacity(cap);
      burst_mode = ($urandom_range(0, 3) == 0);
      if (phase % 4 == 2) begin
        // empty the bag, then fill with each extreme to reach the sum limits
        while (mirror_held != 0) offer_item(BAG_DEL, mirror_slots[0]);
        repeat (DEPTH + 1) offer_item(BAG_ADD, 32'h7FFFFFFF);
        offer_item(BAG_DEL, 32'h7FFFFFFF);
        repeat (DEPTH + 1) offer_item(BAG_ADD, 32'h80000000);
        offer_item(BAG_DEL, 32'h80000000);
      end else begin
        // small pool of values so deletes find duplicates
        for (int i = 0; i < 6; i++) begin
          r = $urandom_range(0, 9);
          case (r)
            0: pool[i] = 32'h7FFFFFFF;
            1: pool[i] = 32'h80000000;
            2: pool[i] = 32'd1;
            3: pool[i] = 32'd0;
            4: pool[i] = 32'hFFFFFFFF;
            default: pool[i] = $urandom;
          endcase
        end
        del_pct = $urandom_range(15, 45);
        n = $urandom_range(40, 100);
        repeat (n) begin
          op = ($urandom_range(0, 99) < del_pct) ? BAG_DEL : BAG_ADD;
          val = ($urandom_range(0, 19) == 0) ? $urandom : pool[$urandom_range(0, 5)];
          offer_item(op, val);
        end
      end
      phase++;
    end

    // drain
    s_tvalid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_summaries.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
        while (!m_tvalid) @(posedge clk);
      end
    end
  end

  // compare each result with the oldest pending summary
  always @(posedge clk) begin
    bag_summary_t got;
    bag_summary_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.count = m_tdata[CNT_OUT_W-1:0];
      got.largest = m_tdata[CNT_OUT_W +: VAL_W];
      got.smallest = m_tdata[CNT_OUT_W+VAL_W +: VAL_W];
      got.total = m_tdata[CNT_OUT_W+2*VAL_W +: SUM_W];
      got.dropped = m_tuser[0];
      results_seen++;
      if (pending_summaries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing pending", results_seen);
      end else begin
        want = pending_summaries.pop_front();
        if (got.count !== want.count || got.largest !== want.largest ||
            got.smallest !== want.smallest || got.total !== want.total ||
            got.dropped !== want.dropped) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected cnt=%0d max=%0d min=%0d sum=%0d drop=%0b",
              results_seen, want.count, $signed(want.largest), $signed(want.smallest),
              $signed(want.total), want.dropped);
            $display("  got cnt=%0d max=%0d min=%0d sum=%0d drop=%0b",
              got.count, $signed(got.largest), $signed(got.smallest),
              $signed(got.total), got.dropped);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

>>> bounded_bag_with_aggregates.f
+incdir+rtl
rtl/bbag_pkg.sv
rtl/bbag_datapath.sv
rtl/bounded_bag_with_aggregates.sv
sim/tb_bounded_bag_with_aggregates.sv
